### design/sta_pkg.sv
// shared constants and types for the session table
`default_nettype none
package sta_pkg;

  localparam int STA_SLOTS     = 64;
  localparam int STA_TIME_BITS = 32;

  localparam int KEY_W     = 50;
  localparam int FUNC_W    = 3;
  localparam int KIND_W    = 3;
  localparam int TIMEOUT_W = 32;
  localparam int DRAIN_W   = 7;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(60);
  localparam logic [DRAIN_W-1:0]   DRAIN_RST   = DRAIN_W'(1);

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_DRAIN   = 1'b1;

  localparam logic [FUNC_W-1:0] FUNC_CREATE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CHECK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SWEEP  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DRAIN  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd5;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATED  = 3'd0,
    KIND_EXTENDED = 3'd1,
    KIND_PRESENT  = 3'd2,
    KIND_ABSENT   = 3'd3,
    KIND_REMOVED  = 3'd4,
    KIND_DONE     = 3'd5,
    KIND_FULL     = 3'd6
  } kind_t;

endpackage
`default_nettype wire

### design/sta_store.sv
// entry memory: key and start tick per slot, one write and one registered read port
`default_nettype none
module sta_store import sta_pkg::*; #(
  parameter int DEPTH = STA_SLOTS,
  parameter int WIDTH = KEY_W + STA_TIME_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/session_table_with_aging.sv
// session table top level: request sequencer, valid bits, tick counter and config registers
//
// Session table of SLOTS entries keyed by a 50-bit identity, aged by an internal
// wrapping tick counter. Requests are handled one at a time. Create, check,
// remove, sweep and drain walk every slot through the single read port of the
// entry memory, and such a request can be held up while the result side stalls;
// tick and unused codes skip the walk. A new request is taken while the last
// result still waits in the output register.
// Valid bits live in flip-flops, so the table is usable right after reset.
`default_nettype none
module session_table_with_aging import sta_pkg::*; #(
  parameter int SLOTS     = STA_SLOTS,
  parameter int TIME_BITS = STA_TIME_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [FUNC_W-1:0] in_func,
  input  wire logic [KEY_W-1:0]  in_imsi,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [KIND_W-1:0]      out_kind,
  output logic [KEY_W-1:0]       out_imsi_res,
  output logic                   out_table_empty,
  output logic                   out_last,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMP_W = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;
  localparam int ENT_W = KEY_W + TIME_BITS;
  localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(SLOTS - 1);
  localparam logic [DRAIN_W-1:0] SLOTS_LIM = DRAIN_W'(SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_CHK2,
    ST_FLUSH
  } state_t;

  state_t               state_r;
  logic [FUNC_W-1:0]    func_r;
  logic [KEY_W-1:0]     key_r;
  logic [TIME_BITS-1:0] tick_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [DRAIN_W-1:0]   drain_r;
  logic [SLOTS-1:0]     valid_r;

  logic                 iss_busy_r;
  logic [IDX_W-1:0]     iss_idx_r;
  logic                 cmp_valid_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 match_r;
  logic [IDX_W-1:0]     match_idx_r;
  logic [TIME_BITS-1:0] match_time_r;
  logic                 free_r;
  logic [IDX_W-1:0]     free_idx_r;
  logic [DRAIN_W-1:0]   cnt_r;

  logic                 pend_valid_r;
  kind_t                pend_kind_r;
  logic [KEY_W-1:0]     pend_key_r;
  logic                 pend_empty_r;

  logic                 out_valid_r;
  kind_t                out_kind_r;
  logic [KEY_W-1:0]     out_key_r;
  logic                 out_empty_r;
  logic                 out_last_r;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [ENT_W-1:0]     mem_wdata;
  logic                 mem_re;
  logic [ENT_W-1:0]     mem_rdata;

  logic [KEY_W-1:0]     rd_key;
  logic [TIME_BITS-1:0] rd_time;
  logic [TIME_BITS-1:0] rd_age;
  logic [TIME_BITS-1:0] m_age;
  logic                 rd_expired;
  logic                 m_expired;
  logic                 cur_valid;
  logic [DRAIN_W-1:0]   drain_lim;
  logic [SLOTS-1:0]     cmp_onehot;
  logic [SLOTS-1:0]     match_onehot;
  logic                 emit_ok;
  logic                 cand;
  logic                 scan_adv;
  logic                 issue;
  logic                 push_en;
  kind_t                push_kind;
  logic [KEY_W-1:0]     push_key;
  logic                 push_empty;
  logic                 flush_en;
  logic                 cfg_we;

  sta_store #(
    .DEPTH (SLOTS),
    .WIDTH (ENT_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (iss_idx_r),
    .rdata (mem_rdata)
  );

  assign rd_key     = mem_rdata[ENT_W-1 -: KEY_W];
  assign rd_time    = mem_rdata[TIME_BITS-1:0];
  assign rd_age     = tick_r - rd_time;
  assign m_age      = tick_r - match_time_r;
  assign rd_expired = CMP_W'(rd_age) > CMP_W'(timeout_r);
  assign m_expired  = CMP_W'(m_age) > CMP_W'(timeout_r);
  assign cur_valid  = valid_r[cmp_idx_r];
  assign cmp_onehot   = SLOTS'(1) << cmp_idx_r;
  assign match_onehot = SLOTS'(1) << match_idx_r;

  always_comb begin
    if (drain_r == '0) begin
      drain_lim = DRAIN_W'(1);
    end else if (drain_r > SLOTS_LIM) begin
      drain_lim = SLOTS_LIM;
    end else begin
      drain_lim = drain_r;
    end
  end

  assign emit_ok = !out_valid_r || !out_stall;

  always_comb begin
    cand = 1'b0;
    if (state_r == ST_SCAN && cmp_valid_r && cur_valid) begin
      if (func_r == FUNC_SWEEP) begin
        cand = rd_expired;
      end else if (func_r == FUNC_DRAIN) begin
        cand = cnt_r < drain_lim;
      end
    end
  end

  assign scan_adv = !(cand && pend_valid_r && !emit_ok);
  assign issue    = (state_r == ST_SCAN) && scan_adv && iss_busy_r;
  assign mem_re   = issue;

  assign mem_we    = (state_r == ST_FINISH) && (func_r == FUNC_CREATE) && (match_r || free_r);
  assign mem_waddr = match_r ? match_idx_r : free_idx_r;
  assign mem_wdata = {key_r, tick_r};

  // result candidates go to a one-deep holding stage so the final one can be marked
  always_comb begin
    push_en    = 1'b0;
    push_kind  = KIND_DONE;
    push_key   = key_r;
    push_empty = (valid_r == '0);
    unique case (state_r)
      ST_SCAN: begin
        push_en    = cand && scan_adv;
        push_kind  = KIND_REMOVED;
        push_key   = rd_key;
        push_empty = ((valid_r & ~cmp_onehot) == '0);
      end
      ST_FINISH: begin
        push_en = 1'b1;
        unique case (func_r)
          FUNC_CREATE: begin
            push_empty = 1'b0;
            if (match_r) begin
              push_kind = KIND_EXTENDED;
            end else if (free_r) begin
              push_kind = KIND_CREATED;
            end else begin
              push_kind = KIND_FULL;
            end
          end
          FUNC_CHECK: begin
            if (match_r && m_expired) begin
              push_kind  = KIND_REMOVED;
              push_empty = ((valid_r & ~match_onehot) == '0);
            end else if (match_r) begin
              push_kind = KIND_PRESENT;
            end else begin
              push_kind = KIND_ABSENT;
            end
          end
          FUNC_REMOVE: begin
            push_kind = KIND_REMOVED;
            if (match_r) begin
              push_empty = ((valid_r & ~match_onehot) == '0);
            end
          end
          default: begin
            push_en = 1'b0;
          end
        endcase
      end
      ST_CHK2: begin
        push_en   = emit_ok;
        push_kind = KIND_ABSENT;
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  assign flush_en = (state_r == ST_FLUSH) && emit_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      tick_r       <= '0;
      iss_busy_r   <= 1'b0;
      cmp_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // output register and holding stage
      if (push_en && pend_valid_r) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= pend_kind_r;
        out_key_r   <= pend_key_r;
        out_empty_r <= pend_empty_r;
        out_last_r  <= 1'b0;
      end else if (flush_en) begin
        out_valid_r <= 1'b1;
        out_last_r  <= 1'b1;
        if (pend_valid_r) begin
          out_kind_r  <= pend_kind_r;
          out_key_r   <= pend_key_r;
          out_empty_r <= pend_empty_r;
        end else begin
          out_kind_r  <= KIND_DONE;
          out_key_r   <= '0;
          out_empty_r <= (valid_r == '0);
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (push_en) begin
        pend_valid_r <= 1'b1;
        pend_kind_r  <= push_kind;
        pend_key_r   <= push_key;
        pend_empty_r <= push_empty;
      end else if (flush_en) begin
        pend_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            func_r      <= in_func;
            key_r       <= in_imsi;
            cnt_r       <= '0;
            match_r     <= 1'b0;
            free_r      <= 1'b0;
            cmp_valid_r <= 1'b0;
            iss_idx_r   <= '0;
            if (in_func <= FUNC_DRAIN) begin
              iss_busy_r <= 1'b1;
              state_r    <= ST_SCAN;
            end else begin
              if (in_func == FUNC_TICK) begin
                tick_r <= tick_r + 1'b1;
              end
              state_r <= ST_FLUSH;
            end
          end
        end
        ST_SCAN: begin
          if (scan_adv) begin
            cmp_valid_r <= issue;
            if (issue) begin
              cmp_idx_r <= iss_idx_r;
              if (iss_idx_r == LAST_IDX) begin
                iss_busy_r <= 1'b0;
              end else begin
                iss_idx_r <= iss_idx_r + 1'b1;
              end
            end
            if (cmp_valid_r) begin
              if (cand) begin
                valid_r[cmp_idx_r] <= 1'b0;
                cnt_r              <= cnt_r + 1'b1;
              end
              if (cur_valid && rd_key == key_r && !match_r) begin
                match_r      <= 1'b1;
                match_idx_r  <= cmp_idx_r;
                match_time_r <= rd_time;
              end
              if (!cur_valid && !free_r) begin
                free_r     <= 1'b1;
                free_idx_r <= cmp_idx_r;
              end
              if (cmp_idx_r == LAST_IDX) begin
                if (func_r == FUNC_SWEEP || func_r == FUNC_DRAIN) begin
                  state_r <= ST_FLUSH;
                end else begin
                  state_r <= ST_FINISH;
                end
              end
            end
          end
        end
        ST_FINISH: begin
          unique case (func_r)
            FUNC_CREATE: begin
              state_r <= ST_FLUSH;
              if (!match_r && free_r) begin
                valid_r[free_idx_r] <= 1'b1;
              end
            end
            FUNC_CHECK: begin
              if (match_r && m_expired) begin
                valid_r[match_idx_r] <= 1'b0;
                state_r              <= ST_CHK2;
              end else begin
                state_r <= ST_FLUSH;
              end
            end
            FUNC_REMOVE: begin
              state_r <= ST_FLUSH;
              if (match_r) begin
                valid_r[match_idx_r] <= 1'b0;
              end
            end
            default: begin
              state_r <= ST_FLUSH;
            end
          endcase
        end
        ST_CHK2: begin
          if (emit_ok) begin
            state_r <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (emit_ok) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // configuration registers
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      drain_r   <= DRAIN_RST;
    end else if (cfg_we) begin
      if (paddr[2] == CFG_TIMEOUT) begin
        timeout_r <= pwdata[TIMEOUT_W-1:0];
      end else begin
        drain_r <= pwdata[DRAIN_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == CFG_DRAIN) ? APB_DW'(drain_r) : APB_DW'(timeout_r);
  assign pready = 1'b1;

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_imsi_res    = out_key_r;
  assign out_table_empty = out_empty_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire
